// File: hw/rtl/fvn_pkg.sv
// Shared constants, record types and a blend helper function for the fractal value noise block.
package fvn_pkg;

   localparam int SCALE_W  = 24;
   localparam int DETAIL_W = 17;
   localparam int COORD_W  = 24;
   localparam int NOISE_W  = 16;
   localparam int SUM_W    = 48;
   localparam int NORM_W   = 33;
   localparam int AMP_W    = 32;
   localparam int PERS_W   = 16;
   localparam int QUO_W    = 16;
   localparam int HASH_LAT = 5;
   localparam int CELL_LAT = 9;

   localparam logic [31:0] HASH_MUL_X   = 32'd442811128;
   localparam logic [31:0] HASH_MUL_Y   = 32'd442381631;
   localparam logic [29:0] HASH_BIAS    = 30'd559184609;
   localparam logic [16:0] ONE_Q16      = 17'h10000;
   localparam logic [17:0] THREE_Q16    = 18'd196608;
   localparam logic [31:0] OFFSET_X     = 32'd17;
   localparam logic [31:0] OFFSET_Y     = 32'd29;
   localparam logic [31:0] AMP_START    = 32'h8000_0000;
   localparam logic [DETAIL_W-1:0] DETAIL_ONE = 17'h10000;

   localparam logic [SCALE_W-1:0]  NOISE_SCALE_RESET  = 24'd65536;
   localparam logic [DETAIL_W-1:0] DETAIL_LEVEL_RESET = 17'd32768;

   localparam logic REG_NOISE_SCALE  = 1'b0;
   localparam logic REG_DETAIL_LEVEL = 1'b1;

   typedef struct packed {
      logic [SUM_W-1:0]  sum;
      logic [NORM_W-1:0] norm;
      logic [AMP_W-1:0]  amp;
   } acc_type;

   typedef struct packed {
      logic [SUM_W-1:0]  rem;
      logic [NORM_W-1:0] norm;
      logic [QUO_W-1:0]  quo;
   } div_type;

   function automatic logic [NOISE_W-1:0] blend(input logic [NOISE_W-1:0] a,
                                                input logic [NOISE_W-1:0] b,
                                                input logic [16:0] w);
      logic [33:0] t;
      t = 34'(a) * 34'(ONE_Q16 - w) + 34'(b) * 34'(w);
      return t[31:16];
   endfunction

endpackage

// File: hw/rtl/fvn_hash.sv
// Pipelined lattice hash: fract-style mix of one integer cell pair into a Q0.16 value.
module fvn_hash (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] cell_x,
   input  logic [31:0] cell_y,
   output logic [15:0] hash
);

   logic [63:0] mx_in;
   logic [63:0] my_in;
   logic [31:0] wx_ff;
   logic [31:0] wy_ff;

   logic [32:0] s_in;
   logic [63:0] pp_in;
   logic [62:0] tt_in;
   logic [32:0] s2_ff;
   logic [31:0] pp_ff;
   logic [38:0] tt_ff;

   logic [39:0] mixed_in;
   logic [32:0] s3_ff;
   logic [39:0] mixed_ff;

   logic [56:0] lo_in;
   logic [48:0] hi_in;
   logic [56:0] lo_ff;
   logic [39:0] hi_ff;

   logic [63:0] total_in;
   logic [15:0] hash_ff;

   assign mx_in    = 64'(cell_x) * 64'(fvn_pkg::HASH_MUL_X);
   assign my_in    = 64'(cell_y) * 64'(fvn_pkg::HASH_MUL_Y);
   assign s_in     = 33'(wx_ff) + 33'(wy_ff);
   assign pp_in    = 64'(wx_ff) * 64'(wy_ff);
   assign tt_in    = 63'(s_in) * 63'(fvn_pkg::HASH_BIAS);
   assign mixed_in = 40'({pp_ff, 1'b0}) + 40'(tt_ff);
   assign lo_in    = 57'(s3_ff) * 57'(mixed_ff[23:0]);
   assign hi_in    = 49'(s3_ff) * 49'(mixed_ff[39:24]);
   assign total_in = 64'(lo_ff) + {hi_ff, 24'd0};

   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff    <= mx_in[31:0];
         wy_ff    <= my_in[31:0];
         s2_ff    <= s_in;
         pp_ff    <= pp_in[63:32];
         tt_ff    <= tt_in[62:24];
         s3_ff    <= s2_ff;
         mixed_ff <= mixed_in;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in[39:0];
         hash_ff  <= total_in[63:48];
      end
   end

   assign hash = hash_ff;

endmodule

// File: hw/rtl/fvn_octave_cell.sv
// One octave cell: lattice hashes, smoothstep, bilinear blend and weighted accumulation.
module fvn_octave_cell #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic [15:0]               persist,
   input  logic                      in_valid,
   input  logic [FRACTION_BITS+31:0] in_pos_x,
   input  logic [FRACTION_BITS+31:0] in_pos_y,
   input  fvn_pkg::acc_type          in_acc,
   output logic                      out_valid,
   output logic [FRACTION_BITS+31:0] out_pos_x,
   output logic [FRACTION_BITS+31:0] out_pos_y,
   output fvn_pkg::acc_type          out_acc
);

   localparam int POS_W = FRACTION_BITS + 32;
   localparam int LAT   = fvn_pkg::CELL_LAT;
   localparam int WDLY  = fvn_pkg::HASH_LAT - 1;

   logic [31:0] cx;
   logic [31:0] cy;
   logic [31:0] cx1;
   logic [31:0] cy1;
   logic [15:0] h00;
   logic [15:0] h10;
   logic [15:0] h01;
   logic [15:0] h11;

   logic [15:0] lx;
   logic [15:0] ly;
   logic [31:0] sqx_in;
   logic [31:0] sqy_in;
   logic [15:0] lx_ff;
   logic [15:0] ly_ff;
   logic [15:0] l2x_ff;
   logic [15:0] l2y_ff;
   logic [17:0] kx_in;
   logic [17:0] ky_in;
   logic [33:0] smx_in;
   logic [33:0] smy_in;
   logic [16:0] wx_ff [WDLY];
   logic [16:0] wy_ff [WDLY];

   logic [15:0] bottom_ff;
   logic [15:0] top_ff;
   logic [16:0] wy6_ff;
   logic [15:0] noise_ff;
   logic [47:0] prod_ff;

   logic [POS_W-1:0]       nx_in;
   logic [POS_W-1:0]       ny_in;
   logic [POS_W-1:0]       pos_x_ff [LAT];
   logic [POS_W-1:0]       pos_y_ff [LAT];
   fvn_pkg::acc_type       acc_ff [LAT];
   fvn_pkg::acc_type       acc_in;
   logic [47:0]            amp_prod_in;
   logic [LAT-1:0]         valid_ff;

   assign cx  = in_pos_x[POS_W-1:FRACTION_BITS];
   assign cy  = in_pos_y[POS_W-1:FRACTION_BITS];
   assign cx1 = cx + 32'd1;
   assign cy1 = cy + 32'd1;

   fvn_hash u_h00 (.clock(clock), .en(en), .cell_x(cx),  .cell_y(cy),  .hash(h00));
   fvn_hash u_h10 (.clock(clock), .en(en), .cell_x(cx1), .cell_y(cy),  .hash(h10));
   fvn_hash u_h01 (.clock(clock), .en(en), .cell_x(cx),  .cell_y(cy1), .hash(h01));
   fvn_hash u_h11 (.clock(clock), .en(en), .cell_x(cx1), .cell_y(cy1), .hash(h11));

   generate
      if (FRACTION_BITS >= 16) begin : g_frac_trunc
         assign lx = in_pos_x[FRACTION_BITS-1 -: 16];
         assign ly = in_pos_y[FRACTION_BITS-1 -: 16];
      end else begin : g_frac_widen
         assign lx = {in_pos_x[FRACTION_BITS-1:0], {(16-FRACTION_BITS){1'b0}}};
         assign ly = {in_pos_y[FRACTION_BITS-1:0], {(16-FRACTION_BITS){1'b0}}};
      end
   endgenerate

   assign sqx_in = 32'(lx) * 32'(lx);
   assign sqy_in = 32'(ly) * 32'(ly);
   assign kx_in  = fvn_pkg::THREE_Q16 - 18'({lx_ff, 1'b0});
   assign ky_in  = fvn_pkg::THREE_Q16 - 18'({ly_ff, 1'b0});
   assign smx_in = 34'(l2x_ff) * 34'(kx_in);
   assign smy_in = 34'(l2y_ff) * 34'(ky_in);

   // next octave position: 2*pos + offset, wrapping
   assign nx_in = {in_pos_x[POS_W-2:0], 1'b0} + POS_W'({fvn_pkg::OFFSET_X, {FRACTION_BITS{1'b0}}});
   assign ny_in = {in_pos_y[POS_W-2:0], 1'b0} + POS_W'({fvn_pkg::OFFSET_Y, {FRACTION_BITS{1'b0}}});

   assign amp_prod_in = 48'(acc_ff[LAT-2].amp) * 48'(persist);
   always_comb begin
      acc_in      = acc_ff[LAT-2];
      acc_in.sum  = acc_ff[LAT-2].sum + prod_ff;
      acc_in.norm = acc_ff[LAT-2].norm + fvn_pkg::NORM_W'(acc_ff[LAT-2].amp);
      acc_in.amp  = amp_prod_in[47:16];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lx_ff     <= lx;
         ly_ff     <= ly;
         l2x_ff    <= sqx_in[31:16];
         l2y_ff    <= sqy_in[31:16];
         wx_ff[0]  <= smx_in[32:16];
         wy_ff[0]  <= smy_in[32:16];
         for (int i = 1; i < WDLY; i++) begin
            wx_ff[i] <= wx_ff[i-1];
            wy_ff[i] <= wy_ff[i-1];
         end
         bottom_ff <= fvn_pkg::blend(h00, h10, wx_ff[WDLY-1]);
         top_ff    <= fvn_pkg::blend(h01, h11, wx_ff[WDLY-1]);
         wy6_ff    <= wy_ff[WDLY-1];
         noise_ff  <= fvn_pkg::blend(bottom_ff, top_ff, wy6_ff);
         prod_ff   <= 48'(noise_ff) * 48'(acc_ff[LAT-3].amp);

         pos_x_ff[0] <= nx_in;
         pos_y_ff[0] <= ny_in;
         acc_ff[0]   <= in_acc;
         for (int i = 1; i < LAT; i++) begin
            pos_x_ff[i] <= pos_x_ff[i-1];
            pos_y_ff[i] <= pos_y_ff[i-1];
         end
         for (int i = 1; i < LAT - 1; i++) begin
            acc_ff[i] <= acc_ff[i-1];
         end
         acc_ff[LAT-1] <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LAT-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[LAT-1];
   assign out_pos_x = pos_x_ff[LAT-1];
   assign out_pos_y = pos_y_ff[LAT-1];
   assign out_acc   = acc_ff[LAT-1];

endmodule

// File: hw/rtl/fvn_div_cell.sv
// One restoring-division cell: settles one quotient bit of sum / norm.
module fvn_div_cell #(
   parameter int BIT = 15
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  fvn_pkg::div_type in_div,
   output logic             out_valid,
   output fvn_pkg::div_type out_div
);

   logic [fvn_pkg::SUM_W:0] divisor;
   logic [fvn_pkg::SUM_W:0] rem_ext;
   logic [fvn_pkg::SUM_W:0] diff;
   logic                    take;
   fvn_pkg::div_type        div_in;
   fvn_pkg::div_type        div_ff;
   logic                    valid_ff;

   assign divisor = (fvn_pkg::SUM_W + 1)'(in_div.norm) << BIT;
   assign rem_ext = {1'b0, in_div.rem};
   assign take    = rem_ext >= divisor;
   assign diff    = rem_ext - divisor;

   always_comb begin
      div_in = in_div;
      if (take) begin
         div_in.rem      = diff[fvn_pkg::SUM_W-1:0];
         div_in.quo[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff <= div_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;

endmodule

// File: hw/rtl/fractal_value_noise_2d.sv
// Top level of the fractal value noise block: registers, scaling, octave chain, divider.
//
//   channel   direction  transfer when          payload
//   req       in         req_valid & req_ready  req_u_coord, req_v_coord (Q8.16)
//   rsp       out        rsp_valid & rsp_ready  rsp_noise_value (Q0.16)
//   csr       in/out     psel&penable&pwrite    paddr, pwdata, prdata
//
// One item per cycle unless a waiting result stalls the output; data passes the input
// registers, the octave cells, the one-bit-per-cell divider chain and the output register.
// Synchronous active-high reset clears valids and loads the register defaults. A waiting result
// that is not taken freezes the whole pipeline and drops req_ready; nothing is lost.
module fractal_value_noise_2d #(
   parameter int OCTAVE_COUNT  = 4,
   parameter int FRACTION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [23:0] req_u_coord,
   input  logic [23:0] req_v_coord,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_noise_value,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int POS_W     = FRACTION_BITS + 32;
   localparam int FLOOR_RAW = ((2 ** FRACTION_BITS) + 5000) / 10000;
   localparam int FLOOR_MAG = (FLOOR_RAW < 1) ? 1 : FLOOR_RAW;
   localparam int QW        = fvn_pkg::QUO_W;

   logic [fvn_pkg::SCALE_W-1:0]  scale_ff;
   logic [fvn_pkg::DETAIL_W-1:0] detail_ff;
   logic                         wr_en;
   logic                         reg_sel;

   logic                         en;
   logic [23:0]                  mag;
   logic [23:0]                  mag_abs;
   logic [fvn_pkg::DETAIL_W-1:0] detail_clamp;
   logic [15:0]                  persist;

   logic signed [23:0] u_ff;
   logic signed [23:0] v_ff;
   logic               va_ff;
   logic signed [47:0] px_ff;
   logic signed [47:0] py_ff;
   logic               vb_ff;
   logic signed [63:0] px_ext;
   logic signed [63:0] py_ext;

   logic                   cvalid [OCTAVE_COUNT+1];
   logic [POS_W-1:0]       cpos_x [OCTAVE_COUNT+1];
   logic [POS_W-1:0]       cpos_y [OCTAVE_COUNT+1];
   fvn_pkg::acc_type       cacc   [OCTAVE_COUNT+1];

   logic                   dvalid [QW+1];
   fvn_pkg::div_type       ddiv   [QW+1];

   logic                   rsp_valid_ff;
   logic [15:0]            rsp_noise_value_ff;

   // register file
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_sel = paddr[2];
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= fvn_pkg::NOISE_SCALE_RESET;
         detail_ff <= fvn_pkg::DETAIL_LEVEL_RESET;
      end else if (wr_en) begin
         unique case (reg_sel)
            fvn_pkg::REG_NOISE_SCALE:  scale_ff  <= pwdata[fvn_pkg::SCALE_W-1:0];
            fvn_pkg::REG_DETAIL_LEVEL: detail_ff <= pwdata[fvn_pkg::DETAIL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         fvn_pkg::REG_NOISE_SCALE:  prdata = 32'(scale_ff);
         fvn_pkg::REG_DETAIL_LEVEL: prdata = 32'(detail_ff);
         default:                   prdata = '0;
      endcase
   end

   // scale magnitude with floor, persistence
   assign mag_abs      = scale_ff[23] ? (24'd0 - scale_ff) : scale_ff;
   assign mag          = (mag_abs < 24'(FLOOR_MAG)) ? 24'(FLOOR_MAG) : mag_abs;
   assign detail_clamp = (detail_ff > fvn_pkg::DETAIL_ONE) ? fvn_pkg::DETAIL_ONE : detail_ff;
   assign persist      = detail_clamp[16:1];

   assign en        = ~rsp_valid_ff | rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff  <= req_u_coord;
         v_ff  <= req_v_coord;
         px_ff <= 48'(u_ff) * $signed(48'(mag));
         py_ff <= 48'(v_ff) * $signed(48'(mag));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (en) begin
         va_ff <= req_valid;
         vb_ff <= va_ff;
      end
   end

   assign px_ext = 64'(px_ff) >>> FRACTION_BITS;
   assign py_ext = 64'(py_ff) >>> FRACTION_BITS;

   assign cvalid[0]   = vb_ff;
   assign cpos_x[0]   = px_ext[POS_W-1:0];
   assign cpos_y[0]   = py_ext[POS_W-1:0];
   assign cacc[0].sum  = '0;
   assign cacc[0].norm = '0;
   assign cacc[0].amp  = fvn_pkg::AMP_START;

   generate
      for (genvar k = 0; k < OCTAVE_COUNT; k++) begin : g_oct
         fvn_octave_cell #(.FRACTION_BITS(FRACTION_BITS)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .persist   (persist),
            .in_valid  (cvalid[k]),
            .in_pos_x  (cpos_x[k]),
            .in_pos_y  (cpos_y[k]),
            .in_acc    (cacc[k]),
            .out_valid (cvalid[k+1]),
            .out_pos_x (cpos_x[k+1]),
            .out_pos_y (cpos_y[k+1]),
            .out_acc   (cacc[k+1])
         );
      end
   endgenerate

   assign dvalid[0]    = cvalid[OCTAVE_COUNT];
   assign ddiv[0].rem  = cacc[OCTAVE_COUNT].sum;
   assign ddiv[0].norm = cacc[OCTAVE_COUNT].norm;
   assign ddiv[0].quo  = '0;

   generate
      for (genvar j = 0; j < QW; j++) begin : g_div
         fvn_div_cell #(.BIT(QW - 1 - j)) u_div (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .in_valid  (dvalid[j]),
            .in_div    (ddiv[j]),
            .out_valid (dvalid[j+1]),
            .out_div   (ddiv[j+1])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_noise_value_ff <= ddiv[QW].quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dvalid[QW];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_value_ff;

endmodule

// File: hw/rtl/fvn_checker.sv
// Port-level assertions for the fractal value noise block, bound to the top level.
module fvn_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_noise_value
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_noise_value))
      else $error("rsp payload changed while stalled");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while pipeline frozen");

   a_free_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input refused with empty output");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result visible right after reset");

endmodule

bind fractal_value_noise_2d fvn_checker u_fvn_checker (.*);
